// File: sv/fqrr_pkg.sv
// Shared types, codes and helpers for the four-queue round-robin dispatcher.
package fqrr_pkg;

  localparam int NUM_QUEUES          = 4;
  localparam int ITEM_W              = 10;
  localparam int DEFAULT_QUEUE_DEPTH = 16;

  // Opcodes
  localparam logic [1:0] OP_SET_DIR = 2'd0;
  localparam logic [1:0] OP_PUSH    = 2'd1;
  localparam logic [1:0] OP_DRAIN   = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;  // no state change, all-zero result

  // Direction codes as written by set-direction
  localparam logic [3:0] DIR_WEST  = 4'd1;
  localparam logic [3:0] DIR_SOUTH = 4'd2;
  localparam logic [3:0] DIR_NORTH = 4'd3;
  localparam logic [3:0] DIR_EAST  = 4'd4;

  // Queue indices, in service order
  localparam logic [1:0] Q_WEST  = 2'd0;
  localparam logic [1:0] Q_NORTH = 2'd1;
  localparam logic [1:0] Q_SOUTH = 2'd2;
  localparam logic [1:0] Q_EAST  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_NO_DIR = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [3:0]        direction_code;
    logic [ITEM_W-1:0] item_number;
  } in_t;

  typedef struct packed {
    logic              item_valid;
    logic [ITEM_W-1:0] item_out;
    logic [1:0]        source_queue;
    logic [1:0]        status;
  } out_t;

  // Operation issued to the queue bank
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [1:0] queue;
  } bank_cmd_t;

  // Occupancy flags returned by the queue bank
  typedef struct packed {
    logic [NUM_QUEUES-1:0] nonempty;
    logic [NUM_QUEUES-1:0] full;
  } bank_stat_t;

  // Direction code to queue: bit 2 set means no direction.
  function automatic logic [2:0] queue_of_code(input logic [3:0] code);
    logic [2:0] q;
    case (code)
      DIR_WEST:  q = {1'b0, Q_WEST};
      DIR_SOUTH: q = {1'b0, Q_SOUTH};
      DIR_NORTH: q = {1'b0, Q_NORTH};
      DIR_EAST:  q = {1'b0, Q_EAST};
      default:   q = 3'b100;
    endcase
    return q;
  endfunction

endpackage

// File: sv/fqrr_queue_bank.sv
// Four circular queues in one shared memory, with head pointers and fill counts.
module fqrr_queue_bank #(
  parameter int QUEUE_DEPTH = fqrr_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  fqrr_pkg::bank_cmd_t         cmd,
  input  logic [fqrr_pkg::ITEM_W-1:0] wr_item,
  output fqrr_pkg::bank_stat_t        stat,
  output logic [fqrr_pkg::ITEM_W-1:0] rd_data
);

  localparam int NQ     = fqrr_pkg::NUM_QUEUES;
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int ADDR_W = $clog2(NQ * QUEUE_DEPTH);
  localparam int MEM_N  = NQ * QUEUE_DEPTH;

  logic [fqrr_pkg::ITEM_W-1:0] mem [MEM_N];

  logic [PTR_W-1:0] head [NQ];
  logic [CNT_W-1:0] fill [NQ];

  logic [PTR_W-1:0]  sel_head;
  logic [CNT_W-1:0]  sel_fill;
  logic [SUM_W-1:0]  tail_sum;
  logic [PTR_W-1:0]  tail_slot;
  logic [PTR_W-1:0]  head_inc;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    for (int q = 0; q < NQ; q++) begin
      stat.nonempty[q] = (fill[q] != '0);
      stat.full[q]     = (fill[q] == CNT_W'(QUEUE_DEPTH));
    end
  end

  assign sel_head = head[cmd.queue];
  assign sel_fill = fill[cmd.queue];

  // head + fill stays below twice the depth: one compare and subtract wraps it
  always_comb begin
    tail_sum = SUM_W'(sel_head) + SUM_W'(sel_fill);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
    end
    tail_slot = tail_sum[PTR_W-1:0];
  end

  assign head_inc = (sel_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : sel_head + PTR_W'(1);
  assign base     = ADDR_W'(cmd.queue) * ADDR_W'(QUEUE_DEPTH);
  assign wr_addr  = base + ADDR_W'(tail_slot);
  assign rd_addr  = base + ADDR_W'(sel_head);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= wr_item;
    end
    if (cmd.pop) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < NQ; q++) begin
        head[q] <= '0;
        fill[q] <= '0;
      end
    end else if (cmd.push) begin
      fill[cmd.queue] <= sel_fill + CNT_W'(1);
    end else if (cmd.pop) begin
      fill[cmd.queue] <= sel_fill - CNT_W'(1);
      head[cmd.queue] <= head_inc;
    end
  end

endmodule

// File: sv/four_queue_round_robin_dispatcher.sv
// Top level of the four-queue round-robin dispatcher.
//
// Usage:
//   Input channel (in_valid/in_ready/in_item) carries one command per
//   transaction: set direction, push an item number onto the queue of the
//   current direction, or drain one item. Output channel (out_valid/
//   out_ready/out_item) returns exactly one result transaction per command.
//   Drain serves the first non-empty queue at or after the service pointer
//   in the order west, north, south, east, then moves the pointer past it.
// Timing: the result of a command accepted at one edge is presented right
//   after that edge. The queue memory read for a drain happens at the accept
//   edge and its registered data is the result payload.
// Throughput: one command per cycle while out_ready is high; the work per
//   command is one priority pick and one memory access.
// Stall: while a result waits and out_ready is low, in_ready is low; the
//   result and all queue state hold.
// Reset: fill counts, head pointers, direction (none) and service pointer
//   (west) clear at once; the queue memory itself is not cleared, and no
//   clearing pass is needed, since only entries holding queued items are read.
module four_queue_round_robin_dispatcher #(
  parameter int QUEUE_DEPTH = fqrr_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  fqrr_pkg::in_t  in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output fqrr_pkg::out_t out_item
);

  fqrr_pkg::bank_cmd_t         cmd;
  fqrr_pkg::bank_stat_t        stat;
  logic [fqrr_pkg::ITEM_W-1:0] rd_data;

  // Control state
  logic [3:0] current_direction;
  logic [1:0] service_pointer;

  // Result register (item_out comes from the bank's read register)
  logic       res_item_valid;
  logic [1:0] res_source;
  logic [1:0] res_status;
  logic       res_item_valid_next;
  logic [1:0] res_source_next;
  logic [1:0] res_status_next;

  logic       accept;
  logic [2:0] push_sel;
  logic       push_dir_ok;
  logic       found;
  logic [1:0] pick_q;
  logic [1:0] scan_q;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign push_sel    = fqrr_pkg::queue_of_code(current_direction);
  assign push_dir_ok = !push_sel[2];

  // Round-robin pick: lowest offset from the service pointer wins
  always_comb begin
    found  = 1'b0;
    pick_q = '0;
    scan_q = '0;
    for (int k = fqrr_pkg::NUM_QUEUES - 1; k >= 0; k--) begin
      scan_q = service_pointer + 2'(k);
      if (stat.nonempty[scan_q]) begin
        found  = 1'b1;
        pick_q = scan_q;
      end
    end
  end

  // Command decode: bank operation and result fields
  always_comb begin
    cmd                 = '0;
    res_item_valid_next = 1'b0;
    res_source_next     = '0;
    res_status_next     = fqrr_pkg::ST_OK;
    case (in_item.opcode)
      fqrr_pkg::OP_SET_DIR: begin
      end
      fqrr_pkg::OP_PUSH: begin
        cmd.queue = push_sel[1:0];
        if (!push_dir_ok) begin
          res_status_next = fqrr_pkg::ST_NO_DIR;
        end else if (stat.full[push_sel[1:0]]) begin
          res_status_next = fqrr_pkg::ST_FULL;
        end else begin
          cmd.push = accept;
        end
      end
      fqrr_pkg::OP_DRAIN: begin
        cmd.queue = pick_q;
        if (found) begin
          cmd.pop             = accept;
          res_item_valid_next = 1'b1;
          res_source_next     = pick_q;
        end else begin
          res_status_next = fqrr_pkg::ST_EMPTY;
        end
      end
      default: begin
        // unused opcode: all-zero result, no state change
      end
    endcase
  end

  fqrr_queue_bank #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_bank (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .wr_item (in_item.item_number),
    .stat    (stat),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      current_direction <= '0;
      service_pointer   <= fqrr_pkg::Q_WEST;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept && in_item.opcode == fqrr_pkg::OP_SET_DIR) begin
        current_direction <= in_item.direction_code;
      end
      if (cmd.pop) begin
        service_pointer <= pick_q + 2'd1;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_item_valid <= res_item_valid_next;
      res_source     <= res_source_next;
      res_status     <= res_status_next;
    end
  end

  always_comb begin
    out_item.item_valid   = res_item_valid;
    out_item.item_out     = res_item_valid ? rd_data : '0;
    out_item.source_queue = res_source;
    out_item.status       = res_status;
  end

  // Checks
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> stat.nonempty[cmd.queue])
    else $error("pop issued to an empty queue");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !stat.full[cmd.queue])
    else $error("push issued to a full queue");

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.pop))
    else $error("push and pop in the same cycle");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  a_valid_item_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.item_valid) |-> (out_item.status == fqrr_pkg::ST_OK))
    else $error("delivered item carries a non-ok status");

endmodule
